FILE: design/mck_pkg.sv
// shared constants, types and code table for the morse keyer
package mck_pkg;

  localparam int UNIT_W = 16;
  localparam int DUR_W  = 19;
  localparam int CHAR_W = 8;

  // duration multiples of one unit
  localparam logic [1:0] MULT_0 = 2'd0;
  localparam logic [1:0] MULT_1 = 2'd1;
  localparam logic [1:0] MULT_3 = 2'd2;
  localparam logic [1:0] MULT_7 = 2'd3;

  localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd1;

  typedef logic [1:0] mult_t;

  // code entry: element count, then elements with the first in bit 0 (1 = dash)
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] pat;
  } morse_code_t;

  localparam int NUM_CODES   = 36;
  localparam int DIGIT_BASE  = 26;

  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_Z     = 8'h7a;

  localparam morse_code_t MORSE_ROM [NUM_CODES] = '{
    '{3'd2, 5'b00010}, '{3'd4, 5'b00001}, '{3'd4, 5'b00101}, '{3'd3, 5'b00001},
    '{3'd1, 5'b00000}, '{3'd4, 5'b00100}, '{3'd3, 5'b00011}, '{3'd4, 5'b00000},
    '{3'd2, 5'b00000}, '{3'd4, 5'b01110}, '{3'd3, 5'b00101}, '{3'd4, 5'b00010},
    '{3'd2, 5'b00011}, '{3'd2, 5'b00001}, '{3'd3, 5'b00111}, '{3'd4, 5'b00110},
    '{3'd4, 5'b01011}, '{3'd3, 5'b00010}, '{3'd3, 5'b00000}, '{3'd1, 5'b00001},
    '{3'd3, 5'b00100}, '{3'd4, 5'b01000}, '{3'd3, 5'b00110}, '{3'd4, 5'b01001},
    '{3'd4, 5'b01101}, '{3'd4, 5'b00011},
    '{3'd5, 5'b11111}, '{3'd5, 5'b11110}, '{3'd5, 5'b11100}, '{3'd5, 5'b11000},
    '{3'd5, 5'b10000}, '{3'd5, 5'b00000}, '{3'd5, 5'b00001}, '{3'd5, 5'b00011},
    '{3'd5, 5'b00111}, '{3'd5, 5'b01111}
  };

endpackage

FILE: design/mck_if.sv
// handshake channels for characters in and lamp segments out
interface mck_char_if;
  logic                      valid;
  logic                      ready;
  logic [mck_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface mck_seg_if;
  logic                      valid;
  logic                      ready;
  logic                      lamp_on;
  logic [mck_pkg::DUR_W-1:0] duration_ticks;
  logic                      char_unknown;
  logic                      message_end;
  logic                      last_segment;

  modport source (output valid, output lamp_on, output duration_ticks,
                  output char_unknown, output message_end, output last_segment,
                  input ready);
  modport sink   (input valid, input lamp_on, input duration_ticks,
                  input char_unknown, input message_end, input last_segment,
                  output ready);
endinterface

FILE: design/morse_code_keyer_top.sv
// morse keyer: one character in, a run of timed lamp segments out
//
//   channel    dir  payload                                        handshake
//   char_chan  in   char_code[7:0]                                 valid/ready
//   seg_chan   out  lamp_on, duration_ticks[18:0], char_unknown,   valid/ready
//                   message_end, last_segment
//   cfg        in   cfg_wr_data[15:0] (unit_length)                cfg_wr_en
//
// a character is taken while the sequencer is idle, then the step sequencer issues one
// segment per cycle unless the output stalls: 2 x elements for letters and digits (2..10),
// one for space, newline and unknown codes; the next character waits for the last segment.
// all durations come from the one shift-add unit.
// reset (rst, synchronous) sets unit_length to 1 and empties the output stage.
// a stalled output holds its segment; the sequencer waits for the slot.
module morse_code_keyer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [mck_pkg::UNIT_W-1:0]  cfg_wr_data,
  mck_char_if.sink                    char_chan,
  mck_seg_if.source                   seg_chan
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  localparam logic [1:0] KIND_CODE  = 2'd0;
  localparam logic [1:0] KIND_SPACE = 2'd1;
  localparam logic [1:0] KIND_NL    = 2'd2;
  localparam logic [1:0] KIND_UNK   = 2'd3;

  logic                       state;
  logic [1:0]                 kind;
  logic [4:0]                 pat;
  logic [2:0]                 len;
  logic [3:0]                 step;
  logic [mck_pkg::UNIT_W-1:0] unit_length;

  logic                       out_valid;
  logic                       out_lamp;
  logic [mck_pkg::DUR_W-1:0]  out_dur;
  logic                       out_unk;
  logic                       out_end;
  logic                       out_last;

  logic                       accept;
  logic                       adv;
  logic [1:0]                 kind_next;
  logic [5:0]                 rom_idx;
  mck_pkg::morse_code_t       code;
  logic [7:0]                 ch_off;

  logic                       seg_lamp;
  mck_pkg::mult_t             seg_mult;
  logic                       seg_unk;
  logic                       seg_end;
  logic                       seg_last;
  logic [mck_pkg::DUR_W-1:0]  seg_dur;

  assign char_chan.ready = (state == ST_IDLE);
  assign accept          = char_chan.valid && char_chan.ready;
  assign adv             = (state == ST_BUSY) && (!out_valid || seg_chan.ready);

  // classify the character and find its code table row
  always_comb begin
    kind_next = KIND_UNK;
    rom_idx   = '0;
    ch_off    = '0;
    if (char_chan.char_code == mck_pkg::CH_NL) begin
      kind_next = KIND_NL;
    end else if (char_chan.char_code == mck_pkg::CH_SPACE) begin
      kind_next = KIND_SPACE;
    end else if (char_chan.char_code inside {[mck_pkg::CH_A:mck_pkg::CH_Z]}) begin
      kind_next = KIND_CODE;
      ch_off    = char_chan.char_code - mck_pkg::CH_A;
      rom_idx   = ch_off[5:0];
    end else if (char_chan.char_code inside {[mck_pkg::CH_ZERO:mck_pkg::CH_NINE]}) begin
      kind_next = KIND_CODE;
      ch_off    = char_chan.char_code - mck_pkg::CH_ZERO + 8'(mck_pkg::DIGIT_BASE);
      rom_idx   = ch_off[5:0];
    end
  end

  assign code = mck_pkg::MORSE_ROM[rom_idx];

  // segment for the current step
  always_comb begin
    seg_lamp = 1'b0;
    seg_mult = mck_pkg::MULT_3;
    seg_unk  = 1'b0;
    seg_end  = 1'b0;
    seg_last = 1'b1;
    case (kind)
      KIND_SPACE: seg_mult = mck_pkg::MULT_7;
      KIND_NL: begin
        seg_mult = mck_pkg::MULT_0;
        seg_end  = 1'b1;
      end
      KIND_UNK: seg_unk = 1'b1;
      KIND_CODE: begin
        if (!step[0]) begin
          // element: dot or dash
          seg_lamp = 1'b1;
          seg_last = 1'b0;
          seg_mult = pat[0] ? mck_pkg::MULT_3 : mck_pkg::MULT_1;
        end else begin
          // gap: inter-element, or the closing character gap
          seg_last = (step[3:1] == len - 3'd1);
          seg_mult = seg_last ? mck_pkg::MULT_3 : mck_pkg::MULT_1;
        end
      end
      default: ;
    endcase
  end

  mck_dur u_dur (
    .unit_length (unit_length),
    .mult        (seg_mult),
    .dur         (seg_dur)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      unit_length <= mck_pkg::UNIT_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unit_length <= cfg_wr_data;
      end
      if (accept) begin
        state <= ST_BUSY;
        step  <= '0;
      end else if (adv) begin
        if (seg_last) begin
          state <= ST_IDLE;
          step  <= '0;
        end else begin
          step <= step + 4'd1;
        end
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (seg_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= kind_next;
      pat  <= code.pat;
      len  <= code.len;
    end else if (adv && !step[0]) begin
      pat <= pat >> 1;
    end
    if (adv) begin
      out_lamp <= seg_lamp;
      out_dur  <= seg_dur;
      out_unk  <= seg_unk;
      out_end  <= seg_end;
      out_last <= seg_last;
    end
  end

  assign seg_chan.valid          = out_valid;
  assign seg_chan.lamp_on        = out_lamp;
  assign seg_chan.duration_ticks = out_dur;
  assign seg_chan.char_unknown   = out_unk;
  assign seg_chan.message_end    = out_end;
  assign seg_chan.last_segment   = out_last;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_BUSY))
    else $error("sequencer did not start after an item");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= 4'd9)
    else $error("step counter past longest run");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (seg_chan.valid && seg_chan.message_end) |-> (seg_chan.duration_ticks == '0))
    else $error("end marker with nonzero duration");

  a_lit_not_last: assert property (@(posedge clk) disable iff (rst)
    (seg_chan.valid && seg_chan.lamp_on) |-> !seg_chan.last_segment)
    else $error("lit segment closed a character");
`endif

endmodule

FILE: design/mck_dur.sv
// shared shift-add unit: unit length times 0, 1, 3 or 7
module mck_dur (
  input  logic [mck_pkg::UNIT_W-1:0] unit_length,
  input  mck_pkg::mult_t             mult,
  output logic [mck_pkg::DUR_W-1:0]  dur
);

  logic [mck_pkg::DUR_W-1:0] u;

  assign u = {{(mck_pkg::DUR_W-mck_pkg::UNIT_W){1'b0}}, unit_length};

  always_comb begin
    case (mult)
      mck_pkg::MULT_0: dur = '0;
      mck_pkg::MULT_1: dur = u;
      mck_pkg::MULT_3: dur = (u << 1) + u;
      mck_pkg::MULT_7: dur = (u << 3) - u;
      default:         dur = '0;
    endcase
  end

endmodule
